/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the chunk stream tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define CST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication checked outside reset.
`define CST_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

/* hw/rtl/cst_pkg.sv */
// Types and constants of the chunk stream reassembly tracker.
package cst_pkg;

  // Chunk header formats.
  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_NO_ID = 2'd1;
  localparam logic [1:0] FMT_DELTA = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  // Header time value that announces an extended timestamp.
  localparam logic [23:0] EXT_MARK = 24'hFFFFFF;
  // Number of extended timestamp bytes.
  localparam logic [16:0] EXT_BYTES = 17'd4;
  // Reset value of the per-chunk payload limit register.
  localparam logic [15:0] PL_LIMIT_RST = 16'd128;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_SHORT       = 2'd1,
    ST_LEN_CHANGED = 2'd2
  } status_t;

  // Decoded chunk header held in the input stage.
  typedef struct packed {
    logic [1:0]  fmt;
    logic [23:0] hdr_time;
    logic [23:0] hdr_length;
    logic [7:0]  hdr_type;
    logic [31:0] hdr_stream_id;
    logic [31:0] ext_time;
    logic [16:0] bytes_avail;
  } hdr_t;

  // One entry of the per-stream table.
  typedef struct packed {
    logic [31:0] tstamp;
    logic [23:0] delta;
    logic [23:0] length;
    logic [7:0]  mtype;
    logic [31:0] msg_id;
    logic [23:0] recv;
  } entry_t;

endpackage

/* hw/rtl/cst_ifs.sv */
// Handshake interfaces for the chunk header word and the result word.

// Chunk header channel.
interface cst_hdr_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fmt;
  logic [5:0]  stream_slot;
  logic [23:0] hdr_time;
  logic [23:0] hdr_length;
  logic [7:0]  hdr_type;
  logic [31:0] hdr_stream_id;
  logic [31:0] ext_time;
  logic [16:0] bytes_avail;

  modport source (
    output valid, fmt, stream_slot, hdr_time, hdr_length, hdr_type,
           hdr_stream_id, ext_time, bytes_avail,
    input  ready
  );
  modport sink (
    input  valid, fmt, stream_slot, hdr_time, hdr_length, hdr_type,
           hdr_stream_id, ext_time, bytes_avail,
    output ready
  );
endinterface

// Result channel.
interface cst_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] consumed;
  logic [15:0] payload_bytes;
  logic        message_done;
  logic [31:0] out_time;
  logic [23:0] out_length;
  logic [7:0]  out_type;
  logic [31:0] out_stream_id;

  modport source (
    output valid, status, consumed, payload_bytes, message_done, out_time,
           out_length, out_type, out_stream_id,
    input  ready
  );
  modport sink (
    input  valid, status, consumed, payload_bytes, message_done, out_time,
           out_length, out_type, out_stream_id,
    output ready
  );
endinterface

/* hw/rtl/chunk_stream_reassembly_tracker.sv */
// Chunk stream reassembly tracker: per-stream header table and chunk accounting.
//
// One decoded chunk header word is accepted per clock cycle, sustained while the
// result port takes words and no table clear runs; its result word passes the
// input stage register and then the output register: the header is registered
// together with the stream table read, the update is computed in one pass and
// lands in the output register while the table entry is written back. The table
// is a single memory of STREAM_SLOTS entries with one write port and one
// registered read port; a one-entry bypass lets back-to-back words on the same
// stream see the entry just written. After reset the table is cleared one entry
// per cycle, with in_ch.ready low until that pass ends; chunk size writes are
// still taken meanwhile. Stream slot numbers are taken modulo STREAM_SLOTS.
`include "assert_macros.svh"

module chunk_stream_reassembly_tracker #(
  parameter int STREAM_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cst_hdr_if.sink     in_ch,
  cst_res_if.source   out_ch
);

  localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

  // Stream table.
  cst_pkg::entry_t mem [STREAM_SLOTS];

  logic [15:0]     pl_limit_r;
  logic            clr_busy_r;
  logic [SW-1:0]   clr_idx_r;

  logic            s1_v_r;
  cst_pkg::hdr_t   s1_hdr_r;
  logic [SW-1:0]   s1_slot_r;
  cst_pkg::entry_t rd_data_r;
  logic            fwd_hit_r;
  cst_pkg::entry_t fwd_data_r;

  logic            out_v_r;
  cst_pkg::status_t out_status_r;
  logic [16:0]     out_consumed_r;
  logic [15:0]     out_payload_r;
  logic            out_done_r;
  cst_pkg::entry_t out_ent_r;

  logic            accept;
  logic            out_load;
  logic            s1_fire;
  logic [SW-1:0]   in_slot;

  // Handshake control.
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = !out_v_r || out_ch.ready;
  assign s1_fire     = s1_v_r && out_load;
  assign in_ch.ready = !clr_busy_r && (!s1_v_r || out_load);

  // Slot number reduced modulo the table depth through a constant lookup.
  always_comb begin
    in_slot = '0;
    for (int k = 0; k < 64; k++) begin
      if (in_ch.stream_slot == 6'(k)) begin
        in_slot = SW'(k % STREAM_SLOTS);
      end
    end
  end

  // Chunk size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_limit_r <= cst_pkg::PL_LIMIT_RST;
    end else if (cfg_we) begin
      pl_limit_r <= cfg_wdata;
    end
  end

  // Clearing pass over the table after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == SW'(STREAM_SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + SW'(1);
    end
  end

  // Table update computed for the word in the input stage.
  cst_pkg::entry_t  cur;
  cst_pkg::entry_t  ent;
  cst_pkg::status_t status;
  logic [16:0]      consumed;
  logic [15:0]      payload;
  logic             done;
  logic             first;
  logic             len_err;
  logic             ext;
  logic [23:0]      span;
  logic [15:0]      pl;
  logic [16:0]      off;
  logic [16:0]      room;
  logic [23:0]      recv_sum;
  logic [31:0]      t_roll;

  assign cur = fwd_hit_r ? fwd_data_r : rd_data_r;

  always_comb begin
    ent      = cur;
    status   = cst_pkg::ST_OK;
    consumed = '0;
    payload  = '0;
    done     = 1'b0;
    len_err  = 1'b0;
    first    = (cur.recv == '0);

    // Header fields and time update.
    if (s1_hdr_r.fmt != cst_pkg::FMT_NONE) begin
      ent.delta = s1_hdr_r.hdr_time;
      if (s1_hdr_r.hdr_time != cst_pkg::EXT_MARK) begin
        if (s1_hdr_r.fmt == cst_pkg::FMT_FULL) begin
          ent.tstamp = {8'd0, s1_hdr_r.hdr_time};
        end else begin
          ent.tstamp = cur.tstamp + {8'd0, s1_hdr_r.hdr_time};
        end
      end
      if (s1_hdr_r.fmt == cst_pkg::FMT_FULL || s1_hdr_r.fmt == cst_pkg::FMT_NO_ID) begin
        if (!first && s1_hdr_r.hdr_length != cur.length) begin
          len_err = 1'b1;
        end else begin
          ent.length = s1_hdr_r.hdr_length;
          ent.mtype  = s1_hdr_r.hdr_type;
          if (s1_hdr_r.fmt == cst_pkg::FMT_FULL) begin
            ent.msg_id = s1_hdr_r.hdr_stream_id;
          end
        end
      end
    end else if (first && cur.delta != cst_pkg::EXT_MARK) begin
      ent.tstamp = cur.tstamp + {8'd0, cur.delta};
    end

    ext = (ent.delta == cst_pkg::EXT_MARK);

    // Time after a payload shortfall: the step's time minus the stored delta.
    if (ext) begin
      t_roll = {1'b0, s1_hdr_r.ext_time[30:0]} - {8'd0, cst_pkg::EXT_MARK};
    end else if (s1_hdr_r.fmt == cst_pkg::FMT_FULL) begin
      t_roll = '0;
    end else if (s1_hdr_r.fmt != cst_pkg::FMT_NONE || first) begin
      t_roll = cur.tstamp;
    end else begin
      t_roll = cur.tstamp - {8'd0, cur.delta};
    end

    // Payload size of this chunk.
    span     = (ent.length > cur.recv) ? (ent.length - cur.recv) : '0;
    pl       = (span > {8'd0, pl_limit_r}) ? pl_limit_r : span[15:0];
    off      = ext ? cst_pkg::EXT_BYTES : '0;
    room     = s1_hdr_r.bytes_avail - off;
    recv_sum = cur.recv + {8'd0, pl};

    // Status and received count.
    if (len_err) begin
      status = cst_pkg::ST_LEN_CHANGED;
    end else if (ext && s1_hdr_r.bytes_avail < cst_pkg::EXT_BYTES) begin
      status = cst_pkg::ST_SHORT;
    end else begin
      if (ext) begin
        ent.tstamp = {1'b0, s1_hdr_r.ext_time[30:0]};
      end
      if ({1'b0, pl} > room) begin
        status     = cst_pkg::ST_SHORT;
        ent.tstamp = t_roll;
      end else begin
        payload  = pl;
        consumed = off + {1'b0, pl};
        if (recv_sum == ent.length) begin
          done     = 1'b1;
          ent.recv = '0;
        end else begin
          ent.recv = recv_sum;
        end
      end
    end
  end

  // Input stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r    <= 1'b1;
        fwd_hit_r <= s1_fire && (s1_slot_r == in_slot);
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // Input stage payload, table read and bypass entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hdr_r.fmt           <= in_ch.fmt;
      s1_hdr_r.hdr_time      <= in_ch.hdr_time;
      s1_hdr_r.hdr_length    <= in_ch.hdr_length;
      s1_hdr_r.hdr_type      <= in_ch.hdr_type;
      s1_hdr_r.hdr_stream_id <= in_ch.hdr_stream_id;
      s1_hdr_r.ext_time      <= in_ch.ext_time;
      s1_hdr_r.bytes_avail   <= in_ch.bytes_avail;
      s1_slot_r              <= in_slot;
      rd_data_r              <= mem[in_slot];
    end
    if (s1_fire) begin
      fwd_data_r <= ent;
    end
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (s1_fire) begin
      mem[s1_slot_r] <= ent;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status_r   <= status;
      out_consumed_r <= consumed;
      out_payload_r  <= payload;
      out_done_r     <= done;
      out_ent_r      <= ent;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.consumed      = out_consumed_r;
  assign out_ch.payload_bytes = out_payload_r;
  assign out_ch.message_done  = out_done_r;
  assign out_ch.out_time      = out_ent_r.tstamp;
  assign out_ch.out_length    = out_ent_r.length;
  assign out_ch.out_type      = out_ent_r.mtype;
  assign out_ch.out_stream_id = out_ent_r.msg_id;

  // No header word is taken while the table is being cleared.
  `CST_ASSERT_IMP(a_no_accept_in_clear, clr_busy_r, !in_ch.ready, "word accepted during clear")
  // Table writes from the datapath never collide with the clearing pass.
  `CST_ASSERT_IMP(a_no_write_in_clear, s1_fire, !clr_busy_r, "table write during clear")
  // A failed chunk carries no byte counts and never completes a message.
  `CST_ASSERT_IMP(a_err_no_counts, out_v_r && out_status_r != cst_pkg::ST_OK,
                  out_consumed_r == '0 && out_payload_r == '0 && !out_done_r,
                  "error result with byte counts")
  // A chunk never carries more payload than the chunk size allows.
  `CST_ASSERT_IMP(a_payload_limit, out_v_r, out_payload_r <= pl_limit_r,
                  "payload above chunk size")

endmodule

/* tb/tb_chunk_stream_reassembly_tracker.sv */
// Self-checking testbench for the chunk stream reassembly tracker.
module tb_chunk_stream_reassembly_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int WORDS_PER_PHASE = 206;
  localparam int AVAIL_TOP = 65539;

  // One chunk header word as offered on the input channel.
  typedef struct packed {
    logic [5:0]    slot;
    cst_pkg::hdr_t h;
  } chunk_word_t;

  // One result word as seen on the output channel.
  typedef struct packed {
    cst_pkg::status_t status;
    logic [16:0] consumed;
    logic [15:0] payload;
    logic        done;
    logic [31:0] tstamp;
    logic [23:0] length;
    logic [7:0]  mtype;
    logic [31:0] msg_id;
  } chunk_res_t;

  // Directed stimulus row; a known result is given only where it is obvious.
  typedef struct {
    chunk_word_t w;
    bit          known;
    chunk_res_t  r;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  cst_hdr_if in_ch ();
  cst_res_if out_ch ();

  chunk_stream_reassembly_tracker #(.STREAM_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the per-stream table and the chunk size register.
  logic [31:0] slot_time  [SLOTS];
  logic [23:0] slot_delta [SLOTS];
  logic [23:0] slot_len   [SLOTS];
  logic [7:0]  slot_type  [SLOTS];
  logic [31:0] slot_msg_id[SLOTS];
  logic [23:0] slot_recv  [SLOTS];
  logic [15:0] pl_limit;

  chunk_res_t due_results[$];
  dir_row_t   dir_rows[$];

  int mismatches;
  int words_sent;
  int msgs_done;
  int short_words;
  int len_changes;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_cycles;

  always #4 clk = ~clk;

  // Chunk accounting for one header word; updates the shadow table.
  function automatic chunk_res_t track_chunk(chunk_word_t w);
    chunk_res_t r;
    logic [5:0] s;
    logic first;
    logic [16:0] offset;
    logic [31:0] pl;
    r = '0;
    r.status = cst_pkg::ST_OK;
    s = w.slot;
    first = (slot_recv[s] == 0);
    offset = '0;
    if (w.h.fmt != cst_pkg::FMT_NONE) begin
      slot_delta[s] = w.h.hdr_time;
      if (w.h.hdr_time != cst_pkg::EXT_MARK) begin
        if (w.h.fmt == cst_pkg::FMT_FULL) begin
          slot_time[s] = {8'd0, w.h.hdr_time};
        end else begin
          slot_time[s] = slot_time[s] + {8'd0, w.h.hdr_time};
        end
      end
      if (w.h.fmt == cst_pkg::FMT_FULL || w.h.fmt == cst_pkg::FMT_NO_ID) begin
        if (!first && w.h.hdr_length != slot_len[s]) begin
          r.status = cst_pkg::ST_LEN_CHANGED;
        end else begin
          slot_len[s] = w.h.hdr_length;
          slot_type[s] = w.h.hdr_type;
          if (w.h.fmt == cst_pkg::FMT_FULL) slot_msg_id[s] = w.h.hdr_stream_id;
        end
      end
    end else if (first && slot_delta[s] != cst_pkg::EXT_MARK) begin
      slot_time[s] = slot_time[s] + {8'd0, slot_delta[s]};
    end

    // Extended timestamp replaces the time, masked to 31 bits.
    if (r.status == cst_pkg::ST_OK && slot_delta[s] == cst_pkg::EXT_MARK) begin
      if (w.h.bytes_avail < cst_pkg::EXT_BYTES) begin
        r.status = cst_pkg::ST_SHORT;
      end else begin
        slot_time[s] = {1'b0, w.h.ext_time[30:0]};
        offset = cst_pkg::EXT_BYTES;
      end
    end

    // Payload is the rest of the message, capped by the chunk size.
    if (r.status == cst_pkg::ST_OK) begin
      pl = (slot_len[s] > slot_recv[s]) ? 32'(slot_len[s] - slot_recv[s]) : 32'd0;
      if (pl > 32'(pl_limit)) pl = 32'(pl_limit);
      if (pl > 32'(w.h.bytes_avail - offset)) begin
        slot_time[s] = slot_time[s] - {8'd0, slot_delta[s]};
        r.status = cst_pkg::ST_SHORT;
      end else begin
        slot_recv[s] = slot_recv[s] + pl[23:0];
        if (slot_recv[s] == slot_len[s]) begin
          slot_recv[s] = '0;
          r.done = 1'b1;
        end
        r.consumed = offset + pl[16:0];
        r.payload = pl[15:0];
      end
    end
    r.tstamp = slot_time[s];
    r.length = slot_len[s];
    r.mtype = slot_type[s];
    r.msg_id = slot_msg_id[s];
    return r;
  endfunction

  function automatic chunk_word_t mk_word(logic [1:0] f, logic [5:0] s, logic [23:0] t,
                                          logic [23:0] l, logic [7:0] ty, logic [31:0] id,
                                          logic [31:0] x, logic [16:0] a);
    chunk_word_t w;
    w.slot = s;
    w.h.fmt = f;
    w.h.hdr_time = t;
    w.h.hdr_length = l;
    w.h.hdr_type = ty;
    w.h.hdr_stream_id = id;
    w.h.ext_time = x;
    w.h.bytes_avail = a;
    return w;
  endfunction

  function automatic chunk_res_t mk_res(cst_pkg::status_t st, logic [16:0] c,
                                        logic [15:0] p, logic d, logic [31:0] t,
                                        logic [23:0] l, logic [7:0] ty, logic [31:0] id);
    chunk_res_t r;
    r.status = st;
    r.consumed = c;
    r.payload = p;
    r.done = d;
    r.tstamp = t;
    r.length = l;
    r.mtype = ty;
    r.msg_id = id;
    return r;
  endfunction

  // Message length: mostly within one or a few chunks of the current size.
  function automatic logic [23:0] pick_length();
    int unsigned top;
    top = (pl_limit == 0) ? 1 : int'(pl_limit);
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return 24'($urandom_range(1, 3 * top));
      default: return 24'($urandom_range(1, top));
    endcase
  endfunction

  // Random header word, mostly a well-formed next chunk for the chosen stream.
  function automatic chunk_word_t pick_chunk();
    chunk_word_t w;
    logic [5:0] s;
    logic [23:0] d;
    logic [23:0] len;
    int unsigned rem;
    int unsigned pl;
    int unsigned need;
    int unsigned sel;
    int unsigned avail;
    w.h.fmt = 2'($urandom_range(0, 3));
    w.h.hdr_time = 24'($urandom);
    w.h.hdr_length = 24'($urandom);
    w.h.hdr_type = 8'($urandom);
    w.h.hdr_stream_id = $urandom;
    w.h.ext_time = $urandom;
    w.h.bytes_avail = 17'($urandom_range(0, AVAIL_TOP));
    // Noise stays off the busy slots so full-range lengths do not park them.
    if ($urandom_range(0, 99) < 15) begin
      w.slot = 6'($urandom_range(8, SLOTS - 1));
      return w;
    end
    s = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, 7));
    w.slot = s;
    sel = $urandom_range(0, 9);
    if (slot_recv[s] == 0) begin
      w.h.fmt = (sel < 4) ? cst_pkg::FMT_FULL : (sel < 8) ? cst_pkg::FMT_NO_ID :
                (sel < 9) ? cst_pkg::FMT_DELTA : cst_pkg::FMT_NONE;
      w.h.hdr_length = pick_length();
    end else begin
      w.h.fmt = (sel < 7) ? cst_pkg::FMT_NONE : (sel < 9) ? cst_pkg::FMT_DELTA :
                cst_pkg::FMT_NO_ID;
      w.h.hdr_length = slot_len[s];
    end
    case ($urandom_range(0, 7))
      0: w.h.hdr_time = cst_pkg::EXT_MARK;
      1: ;
      default: w.h.hdr_time = 24'($urandom_range(0, 1000));
    endcase
    d = (w.h.fmt == cst_pkg::FMT_NONE) ? slot_delta[s] : w.h.hdr_time;
    len = (w.h.fmt == cst_pkg::FMT_FULL || w.h.fmt == cst_pkg::FMT_NO_ID) ?
          w.h.hdr_length : slot_len[s];
    rem = (len > slot_recv[s]) ? int'(len - slot_recv[s]) : 0;
    pl = (rem > 32'(pl_limit)) ? int'(pl_limit) : rem;
    need = pl + ((d == cst_pkg::EXT_MARK) ? 4 : 0);
    // Now and then the chunk arrives short.
    if ($urandom_range(0, 7) == 0) begin
      avail = $urandom_range(0, need);
    end else begin
      avail = need + $urandom_range(0, 3);
      if (avail > AVAIL_TOP) avail = AVAIL_TOP;
    end
    w.h.bytes_avail = 17'(avail);
    return w;
  endfunction

  // Offer one word after an optional gap and wait for the block to take it.
  task automatic send_chunk(chunk_word_t w, bit known, chunk_res_t known_res);
    int unsigned gap;
    chunk_res_t r;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.fmt <= w.h.fmt;
    in_ch.stream_slot <= w.slot;
    in_ch.hdr_time <= w.h.hdr_time;
    in_ch.hdr_length <= w.h.hdr_length;
    in_ch.hdr_type <= w.h.hdr_type;
    in_ch.hdr_stream_id <= w.h.hdr_stream_id;
    in_ch.ext_time <= w.h.ext_time;
    in_ch.bytes_avail <= w.h.bytes_avail;
    in_ch.valid <= 1'b1;
    r = track_chunk(w);
    if (known) r = known_res;
    do @(posedge clk); while (!in_ch.ready);
    due_results.push_back(r);
    words_sent++;
    if (r.done && r.status == cst_pkg::ST_OK) msgs_done++;
    if (r.status == cst_pkg::ST_SHORT) short_words++;
    if (r.status == cst_pkg::ST_LEN_CHANGED) len_changes++;
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pl_limit(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    pl_limit = v;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    chunk_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        e = due_results.pop_front();
        check_field("status", 32'(e.status), 32'(out_ch.status));
        check_field("consumed", 32'(e.consumed), 32'(out_ch.consumed));
        check_field("payload_bytes", 32'(e.payload), 32'(out_ch.payload_bytes));
        check_field("message_done", 32'(e.done), 32'(out_ch.message_done));
        check_field("out_time", e.tstamp, out_ch.out_time);
        check_field("out_length", 32'(e.length), 32'(out_ch.out_length));
        check_field("out_type", 32'(e.mtype), 32'(out_ch.out_type));
        check_field("out_stream_id", e.msg_id, out_ch.out_stream_id);
      end
    end
  end

  // Result side: random back-pressure, plus one long hold when asked.
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Run limit.
  initial begin
    #5ms;
    $display("chunk_stream_reassembly_tracker test failed");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases per chunk size.
  initial begin
    logic [15:0] sizes[5];
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.fmt = '0;
    in_ch.stream_slot = '0;
    in_ch.hdr_time = '0;
    in_ch.hdr_length = '0;
    in_ch.hdr_type = '0;
    in_ch.hdr_stream_id = '0;
    in_ch.ext_time = '0;
    in_ch.bytes_avail = '0;
    mismatches = 0;
    words_sent = 0;
    msgs_done = 0;
    short_words = 0;
    len_changes = 0;
    rx_hold_cycles = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    pl_limit = cst_pkg::PL_LIMIT_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_time[i] = '0;
      slot_delta[i] = '0;
      slot_len[i] = '0;
      slot_type[i] = '0;
      slot_msg_id[i] = '0;
      slot_recv[i] = '0;
    end

    // Whole message in one chunk, then a huge message on the top slot.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_FULL, 0, 100, 100, 20, 1, 0, 100), 1'b1,
                         mk_res(cst_pkg::ST_OK, 100, 100, 1'b1, 100, 100, 20, 1)});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_FULL, 63, 24'hFFFFFE, 24'hFFFFFF, 8'hFF,
                                 32'hFFFFFFFF, 0, 128), 1'b1,
                         mk_res(cst_pkg::ST_OK, 128, 128, 1'b0, 32'hFFFFFE, 24'hFFFFFF,
                                8'hFF, 32'hFFFFFFFF)});
    // Length changed mid-message: the time still moves by the delta.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NO_ID, 63, 10, 5, 1, 0, 0, 200), 1'b1,
                         mk_res(cst_pkg::ST_LEN_CHANGED, 0, 0, 1'b0, 32'h01000008,
                                24'hFFFFFF, 8'hFF, 32'hFFFFFFFF)});
    // Payload shortfall rolls the delta back.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 63, 24'hFFFFFF, 24'hFFFFFF, 8'hFF,
                                 32'hFFFFFFFF, 32'hFFFFFFFF, 0), 1'b1,
                         mk_res(cst_pkg::ST_SHORT, 0, 0, 1'b0, 32'hFFFFFE, 24'hFFFFFF,
                                8'hFF, 32'hFFFFFFFF)});
    // Extended timestamp announced but its bytes are missing.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_FULL, 1, 24'hFFFFFF, 10, 8, 2,
                                 32'hFFFFFFFF, 3), 1'b1,
                         mk_res(cst_pkg::ST_SHORT, 0, 0, 1'b0, 0, 10, 8, 2)});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 1, 0, 0, 0, 0, 32'h80000005, 14), 1'b1,
                         mk_res(cst_pkg::ST_OK, 14, 10, 1'b1, 5, 10, 8, 2)});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 1, 0, 0, 0, 0, 0, 2), 1'b1,
                         mk_res(cst_pkg::ST_SHORT, 0, 0, 1'b0, 5, 10, 8, 2)});
    // Zero-length messages, one with the most bytes available.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_DELTA, 2, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(cst_pkg::ST_OK, 0, 0, 1'b1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_FULL, 5, 0, 0, 8'hAA, 32'h55AA55AA, 0,
                                 17'h10003), 1'b1,
                         mk_res(cst_pkg::ST_OK, 0, 0, 1'b1, 0, 0, 8'hAA, 32'h55AA55AA)});
    // Extended time is masked to 31 bits.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NO_ID, 6, 24'hFFFFFF, 20, 3, 32'hFFFFFFFF,
                                 32'hFFFFFFFF, 24), 1'b1,
                         mk_res(cst_pkg::ST_OK, 24, 20, 1'b1, 32'h7FFFFFFF, 20, 3, 0)});
    // Message spread over three chunks, then a reused delta that falls short.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NO_ID, 3, 24'h000123, 300, 9, 0, 0, 200),
                         1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 3, 0, 0, 0, 0, 0, 128), 1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 3, 0, 0, 0, 0, 0, 44), 1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 3, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // Large deltas that carry the time past 24 bits.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_DELTA, 0, 24'hFFFFFE, 0, 0, 0, 0, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 0, 0, 0, 0, 0, 0, 100), 1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_DELTA, 4, 24'hFFFFFF, 0, 0, 0, 32'h12345678,
                                 17'h10003), 1'b0, '0});
    // Full header mid-message with the same length is accepted.
    dir_rows.push_back('{mk_word(cst_pkg::FMT_FULL, 63, 7, 24'hFFFFFF, 1, 2, 0, 130),
                         1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_NONE, 63, 0, 0, 0, 0, 0, 17'h10003),
                         1'b0, '0});
    dir_rows.push_back('{mk_word(cst_pkg::FMT_DELTA, 7, 1, 0, 0, 0, 0, 5), 1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_chunk(dir_rows[i].w, dir_rows[i].known, dir_rows[i].r);

    sizes[0] = 16'hFFFF;
    sizes[1] = 16'd128;
    sizes[2] = 16'd0;
    sizes[3] = 16'd300;
    sizes[4] = 16'($urandom_range(128, 65535));
    for (int p = 0; p < 5; p++) begin
      drain();
      set_pl_limit(sizes[p]);
      // Idle pattern per phase; phase 1 backs up the block, phase 2 runs flat out.
      tx_idle_on = (p != 1 && p != 2);
      rx_idle_on = (p != 2 && p != 4);
      if (p == 1) rx_hold_cycles = 300;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (p == 3 && i == WORDS_PER_PHASE / 2) drain();
        send_chunk(pick_chunk(), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d chunk words over chunk sizes 128, 65535, 0, 300 and 0x%0h.",
             words_sent, sizes[4]);
    $display("Saw %0d completed messages, %0d short chunks, %0d length changes.",
             msgs_done, short_words, len_changes);
    if (mismatches == 0) begin
      $display("chunk_stream_reassembly_tracker test passed");
    end else begin
      $display("chunk_stream_reassembly_tracker test failed");
    end
    $finish;
  end

endmodule
